>>> sv/tbwp_pkg.sv
// Shared types, widths and codes for the token bucket write pacer.
package tbwp_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int BYTE_WIDTH = 32;
    localparam int TOKEN_BITS = BYTE_WIDTH + FRAC_BITS;
    localparam int RATE_BITS  = 40;
    localparam int CFG_IDX_W  = 2;

    typedef logic [TOKEN_BITS-1:0] tok_t;
    typedef logic [TOKEN_BITS:0]   tok_sum_t;
    typedef logic [RATE_BITS-1:0]  rate_t;
    typedef logic [BYTE_WIDTH-1:0] bytes_t;

    // Action codes
    localparam logic [1:0] ACT_TICK    = 2'd0;
    localparam logic [1:0] ACT_REQUEST = 2'd1;
    localparam logic [1:0] ACT_REFILL  = 2'd2;

    // Status codes
    localparam logic [1:0] ST_NOW    = 2'd0;
    localparam logic [1:0] ST_WAITED = 2'd1;
    localparam logic [1:0] ST_BUSY   = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RATE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BURST = 2'd1;

    typedef struct packed {
        logic [1:0] action;
        bytes_t     request_bytes;
    } item_t;

    typedef struct packed {
        logic [1:0] status;
        bytes_t     granted_bytes;
        bytes_t     waited_ticks;
    } result_t;

    typedef struct packed {
        tok_t   token_count;
        logic   request_pending;
        bytes_t held_bytes;
        bytes_t wait_counter;
    } state_t;

    // Whole bytes to fixed-point tokens
    function automatic tok_t to_tokens(input bytes_t b);
        to_tokens = tok_t'({b, {FRAC_BITS{1'b0}}});
    endfunction

endpackage

>>> sv/token_bucket_write_pacer.sv
// Token bucket write pacer: one item per clock except under the stall described below.
// Items are ticks, byte requests and refills. Each accepted beat lands in an input
// register; when it advances, one pass of add, clamp and compare on the token register
// updates the bucket and, where the item gives one, loads the result register. A new
// item is taken every cycle; the only stall is a result waiting on result_ready while
// the item in the input register also has a result to deliver. Configuration writes
// are taken at any time and must be issued only while the block is idle.
module token_bucket_write_pacer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_ready,
    input  tbwp_pkg::item_t                   item,
    output logic                              result_valid,
    input  logic                              result_ready,
    output tbwp_pkg::result_t                 result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tbwp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tbwp_pkg::RATE_BITS-1:0]    cfg_data
);

    logic              in_valid_reg;
    logic              in_valid_next;
    tbwp_pkg::item_t   in_item_reg;
    tbwp_pkg::rate_t   rate_reg;
    tbwp_pkg::bytes_t  burst_reg;
    tbwp_pkg::state_t  state_reg;
    tbwp_pkg::state_t  state_next;
    tbwp_pkg::result_t step_res;
    logic              step_has_res;
    logic              out_free;
    logic              fire;
    logic              item_take;

    assign cfg_ready = 1'b1;

    tbwp_step u_step (
        .cur     (state_reg),
        .rate    (rate_reg),
        .burst   (burst_reg),
        .item    (in_item_reg),
        .nxt     (state_next),
        .res     (step_res),
        .has_res (step_has_res)
    );

    tbwp_out_reg u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (fire && step_has_res),
        .load_data    (step_res),
        .free         (out_free),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // advance the held item unless its result has nowhere to go
    assign fire          = in_valid_reg && (out_free || !step_has_res);
    assign item_ready    = !in_valid_reg || fire;
    assign item_take     = item_valid && item_ready;
    assign in_valid_next = item_take ? 1'b1 : (in_valid_reg && !fire);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            rate_reg     <= '0;
            burst_reg    <= '0;
            state_reg    <= '0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (fire)
            begin
                state_reg <= state_next;
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == tbwp_pkg::REG_RATE)
                begin
                    rate_reg <= cfg_data;
                end
                else if (cfg_index == tbwp_pkg::REG_BURST)
                begin
                    burst_reg <= cfg_data[tbwp_pkg::BYTE_WIDTH-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            in_item_reg <= item;
        end
    end

endmodule

>>> sv/tbwp_step.sv
// Next-state and result logic for one item of the token bucket write pacer.
module tbwp_step (
    input  tbwp_pkg::state_t  cur,
    input  tbwp_pkg::rate_t   rate,
    input  tbwp_pkg::bytes_t  burst,
    input  tbwp_pkg::item_t   item,
    output tbwp_pkg::state_t  nxt,
    output tbwp_pkg::result_t res,
    output logic              has_res
);

    tbwp_pkg::tok_sum_t sum;
    tbwp_pkg::tok_t     tick_tok;
    tbwp_pkg::tok_t     held_need;
    tbwp_pkg::tok_t     held_cap;
    tbwp_pkg::tok_t     tick_clamp;
    tbwp_pkg::tok_t     req_need;
    tbwp_pkg::tok_t     req_cap;
    tbwp_pkg::tok_t     req_clamp;
    tbwp_pkg::bytes_t   wait_inc;
    tbwp_pkg::bytes_t   req;

    assign req = item.request_bytes;

    // Saturating add of the rate
    assign sum      = tbwp_pkg::tok_sum_t'(cur.token_count) + tbwp_pkg::tok_sum_t'(rate);
    assign tick_tok = sum[tbwp_pkg::TOKEN_BITS] ? '1 : sum[tbwp_pkg::TOKEN_BITS-1:0];

    assign held_need  = tbwp_pkg::to_tokens(cur.held_bytes);
    assign held_cap   = tbwp_pkg::to_tokens((burst > cur.held_bytes) ? burst : cur.held_bytes);
    assign tick_clamp = (tick_tok > held_cap) ? held_cap : tick_tok;
    assign wait_inc   = (cur.wait_counter == '1) ? cur.wait_counter : cur.wait_counter + 1'b1;

    assign req_need  = tbwp_pkg::to_tokens(req);
    assign req_cap   = tbwp_pkg::to_tokens((burst > req) ? burst : req);
    assign req_clamp = (cur.token_count > req_cap) ? req_cap : cur.token_count;

    always_comb
    begin
        nxt     = cur;
        has_res = 1'b0;
        res     = '0;
        case (item.action)
            tbwp_pkg::ACT_TICK:
            begin
                nxt.token_count = tick_tok;
                if (cur.request_pending)
                begin
                    nxt.wait_counter = wait_inc;
                    nxt.token_count  = tick_clamp;
                    if (tick_clamp >= held_need)
                    begin
                        nxt.token_count     = tick_clamp - held_need;
                        nxt.request_pending = 1'b0;
                        nxt.held_bytes      = '0;
                        nxt.wait_counter    = '0;
                        has_res             = 1'b1;
                        res.status          = tbwp_pkg::ST_WAITED;
                        res.granted_bytes   = cur.held_bytes;
                        res.waited_ticks    = wait_inc;
                    end
                end
            end
            tbwp_pkg::ACT_REQUEST:
            begin
                has_res           = 1'b1;
                res.granted_bytes = req;
                if (cur.request_pending)
                begin
                    res.status = tbwp_pkg::ST_BUSY;
                end
                else if (req == '0 || rate == '0 || burst == '0)
                begin
                    res.status = tbwp_pkg::ST_NOW;
                end
                else if (req_clamp >= req_need)
                begin
                    nxt.token_count = req_clamp - req_need;
                    res.status      = tbwp_pkg::ST_NOW;
                end
                else
                begin
                    // hold the request until a tick can grant it
                    has_res             = 1'b0;
                    nxt.token_count     = req_clamp;
                    nxt.request_pending = 1'b1;
                    nxt.held_bytes      = req;
                    nxt.wait_counter    = '0;
                end
            end
            tbwp_pkg::ACT_REFILL:
            begin
                nxt.token_count     = tbwp_pkg::to_tokens(burst);
                nxt.request_pending = 1'b0;
                nxt.held_bytes      = '0;
                nxt.wait_counter    = '0;
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

>>> sv/tbwp_out_reg.sv
// Result register of the token bucket write pacer.
module tbwp_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  tbwp_pkg::result_t load_data,
    output logic              free,
    output logic              result_valid,
    input  logic              result_ready,
    output tbwp_pkg::result_t result
);

    logic              valid_reg;
    logic              valid_next;
    tbwp_pkg::result_t data_reg;

    // slot opens when empty or when the held beat leaves this cycle
    assign free       = !valid_reg || result_ready;
    assign valid_next = load ? 1'b1 : (valid_reg && !result_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign result_valid = valid_reg;
    assign result       = data_reg;

endmodule

>>> test/tb_token_bucket_write_pacer.sv
// Testbench for the token bucket write pacer: directed and random beats checked by a bucket tracker.
module tb_token_bucket_write_pacer;
    import tbwp_pkg::*;

    localparam logic [1:0]           ACT_UNUSED  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    // Tracks the bucket and the held request; holds the grants still owed by the block.
    class bucket_tracker;
        localparam tok_t TOK_FULL = '1;

        rate_t   rate;
        bytes_t  burst;
        tok_t    tokens;
        bit      holding;
        bytes_t  held;
        bytes_t  held_ticks;
        result_t grants_due[$];
        int      errors;

        function new();
            rate       = '0;
            burst      = '0;
            tokens     = '0;
            holding    = 1'b0;
            held       = '0;
            held_ticks = '0;
            errors     = 0;
        endfunction

        function tok_t as_tokens(bytes_t b);
            bit [63:0] wide;
            wide = 64'(b) << FRAC_BITS;
            return (wide > 64'(TOK_FULL)) ? TOK_FULL : tok_t'(wide);
        endfunction

        // Clamp to the capacity for this size, then take the bytes if they are there.
        function bit try_take(bytes_t b);
            bit [63:0] cap;
            bit [63:0] need;
            cap  = 64'(as_tokens((burst > b) ? burst : b));
            need = 64'(b) << FRAC_BITS;
            if (64'(tokens) > cap)
                tokens = tok_t'(cap);
            if (64'(tokens) < need)
                return 1'b0;
            tokens = tok_t'(64'(tokens) - need);
            return 1'b1;
        endfunction

        function void queue_grant(logic [1:0] status, bytes_t nbytes, bytes_t ticks);
            result_t r;
            r.status        = status;
            r.granted_bytes = nbytes;
            r.waited_ticks  = ticks;
            grants_due.push_back(r);
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, rate_t data);
            if (idx == REG_RATE)
                rate = data;
            else if (idx == REG_BURST)
                burst = data[BYTE_WIDTH-1:0];
        endfunction

        function void account_item(item_t beat);
            bit [63:0] sum;
            case (beat.action)
                ACT_TICK:
                begin
                    sum    = 64'(tokens) + 64'(rate);
                    tokens = (sum > 64'(TOK_FULL)) ? TOK_FULL : tok_t'(sum);
                    if (holding)
                    begin
                        if (held_ticks != '1)
                            held_ticks++;
                        if (try_take(held))
                        begin
                            queue_grant(ST_WAITED, held, held_ticks);
                            holding    = 1'b0;
                            held       = '0;
                            held_ticks = '0;
                        end
                    end
                end
                ACT_REQUEST:
                begin
                    if (holding)
                        queue_grant(ST_BUSY, beat.request_bytes, '0);
                    else if (beat.request_bytes == '0 || rate == '0 || burst == '0)
                        queue_grant(ST_NOW, beat.request_bytes, '0);
                    else if (try_take(beat.request_bytes))
                        queue_grant(ST_NOW, beat.request_bytes, '0);
                    else
                    begin
                        holding    = 1'b1;
                        held       = beat.request_bytes;
                        held_ticks = '0;
                    end
                end
                ACT_REFILL:
                begin
                    tokens     = as_tokens(burst);
                    holding    = 1'b0;
                    held       = '0;
                    held_ticks = '0;
                end
                default:
                    ;
            endcase
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        task check_grant(result_t got);
            result_t want;
            if (grants_due.size() == 0)
            begin
                report($sformatf("result with none outstanding: status %0d bytes %0d ticks %0d",
                                 got.status, got.granted_bytes, got.waited_ticks));
                return;
            end
            want = grants_due.pop_front();
            if (got.status != want.status)
                report($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.granted_bytes != want.granted_bytes)
                report($sformatf("granted_bytes %0d, want %0d",
                                 got.granted_bytes, want.granted_bytes));
            if (got.waited_ticks != want.waited_ticks)
                report($sformatf("waited_ticks %0d, want %0d",
                                 got.waited_ticks, want.waited_ticks));
        endtask
    endclass

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 item_valid   = 1'b0;
    logic                 item_ready;
    item_t                item         = '0;
    logic                 result_valid;
    logic                 result_ready = 1'b0;
    result_t              result;
    logic                 cfg_valid    = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index    = '0;
    rate_t                cfg_data     = '0;

    bit steady_in  = 1'b0;
    bit steady_out = 1'b0;

    bucket_tracker tracker = new();

    token_bucket_write_pacer u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Hold valid and payload until the beat is taken; the next beat may follow in the same step.
    task automatic send_item(logic [1:0] act, bytes_t nbytes);
        item_t beat;
        int    gap;
        beat.action        = act;
        beat.request_bytes = nbytes;
        gap = steady_in ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= beat;
        do
            @(posedge clk);
        while (!item_ready);
        tracker.account_item(beat);
    endtask

    // Drop valid and let every owed grant arrive, then wait out silent items still in flight.
    task automatic drain();
        item_valid <= 1'b0;
        while (tracker.grants_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, rate_t data);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        tracker.set_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin : result_side
        int gap;
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                steady_out = !steady_out;
            gap = steady_out ? 0 : $urandom_range(0, 18);
            if (gap > 0)
            begin
                result_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(rst_n && result_valid));
        end
    end

    always @(posedge clk)
        if (rst_n && result_valid && result_ready)
            tracker.check_grant(result);

    initial
    begin : stimulus
        rate_t  rate;
        bytes_t burst;
        bytes_t size_top;
        bytes_t nbytes;
        int     pick;
        int     sel;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero rate and zero burst grant at once; zero bytes too.
        send_item(ACT_REQUEST, '0);
        send_item(ACT_REQUEST, '1);
        write_reg(REG_RATE, rate_t'(100) << FRAC_BITS);
        send_item(ACT_REQUEST, 5);
        write_reg(REG_BURST, 1000);
        send_item(ACT_REFILL, '0);
        send_item(ACT_REQUEST, 400);
        send_item(ACT_REQUEST, 700);
        send_item(ACT_REQUEST, 1);
        send_item(ACT_TICK, '1);
        send_item(ACT_UNUSED, $urandom);
        // Larger than burst: capacity follows the request.
        send_item(ACT_REQUEST, 2000);
        repeat (3) send_item(ACT_TICK, '0);
        // Registers change under a held request.
        write_reg(REG_RATE, '0);
        repeat (2) send_item(ACT_TICK, '0);
        write_reg(REG_SPARE_A, rate_t'({$urandom, $urandom}));
        write_reg(REG_SPARE_B, '1);
        write_reg(REG_RATE, (rate_t'(1000) << FRAC_BITS) | rate_t'(16'h8000));
        repeat (2) send_item(ACT_TICK, '0);
        send_item(ACT_REFILL, '0);
        send_item(ACT_TICK, '0);
        send_item(ACT_REQUEST, 1500);
        send_item(ACT_REQUEST, '1);
        send_item(ACT_REFILL, '0);

        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0:
                begin
                    rate     = (rate_t'(64) << FRAC_BITS) | rate_t'($urandom_range(0, 16'hFFFF));
                    burst    = 512;
                    size_top = 1024;
                end
                1:
                begin
                    rate     = rate_t'(16'h3000);
                    burst    = 4;
                    size_top = 8;
                end
                2:
                begin
                    rate     = '1;
                    burst    = '1;
                    size_top = '1;
                end
                3:
                begin
                    rate     = '0;
                    burst    = $urandom;
                    size_top = $urandom_range(1, 5000);
                end
                4:
                begin
                    rate     = rate_t'({$urandom, $urandom});
                    burst    = '0;
                    size_top = 4000;
                end
                5:
                begin
                    rate     = rate_t'({$urandom, $urandom});
                    burst    = $urandom;
                    size_top = $urandom;
                end
                6:
                begin
                    rate     = rate_t'(7) << FRAC_BITS;
                    burst    = 40;
                    size_top = 100;
                end
                default:
                begin
                    rate     = rate_t'($urandom_range(20, 60)) << FRAC_BITS;
                    burst    = 300;
                    size_top = 600;
                end
            endcase
            write_reg(REG_RATE, rate);
            write_reg(REG_BURST, rate_t'(burst));

            // At the full rate, a long run of ticks drives the idle bucket to its ceiling.
            if (p == 2)
                repeat (300) send_item(ACT_TICK, $urandom);

            repeat (110)
            begin
                if ($urandom_range(0, 39) == 0)
                    steady_in = !steady_in;
                pick = $urandom_range(0, 99);
                if (pick < 55)
                    send_item(ACT_TICK, $urandom);
                else if (pick < 92)
                begin
                    sel = $urandom_range(0, 99);
                    if (sel < 8)
                        nbytes = '0;
                    else if (sel < 13)
                        nbytes = $urandom;
                    else
                        nbytes = $urandom_range(1, size_top);
                    send_item(ACT_REQUEST, nbytes);
                end
                else if (pick < 97)
                    send_item(ACT_REFILL, $urandom);
                else
                    send_item(ACT_UNUSED, $urandom);
            end
        end

        drain();
        repeat (4) @(posedge clk);
        if (tracker.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
